// ===== rtl/core/brpp_pkg.sv =====
package brpp_pkg;

  localparam int HEADER_BYTES   = 12;
  localparam int DATA_BYTES_DEF = 256;
  localparam int QUEUE_DEPTH    = 2;

  localparam int OUT_OFF_W = 9;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_SEND = 1'b1;

  // Beat sequence of one job in the back end
  localparam logic [3:0] STEP_PATCH_LO = 4'd0;
  localparam logic [3:0] STEP_PATCH_HI = 4'd1;
  localparam logic [3:0] STEP_BODY     = 4'd2;
  localparam logic [3:0] STEP_VAL_LO   = 4'd3;
  localparam logic [3:0] STEP_VAL_HI   = 4'd4;
  localparam logic [3:0] STEP_HDR_LAST = 4'd13;

  typedef struct packed {
    logic        is_send;
    logic        patch_en;
    logic        key_en;
    logic [15:0] patch_bits;
    logic [7:0]  key;
    logic [15:0] value;
    logic [31:0] now_time;
    logic [31:0] old_time;
    logic [8:0]  pkt_len;
    logic        full;
  } brpp_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } brpp_q_stat_t;

endpackage

// ===== rtl/core/brpp_front.sv =====
module brpp_front #(
  parameter int DATA_BYTES = brpp_pkg::DATA_BYTES_DEF,
  parameter int OFF_W      = $clog2(brpp_pkg::HEADER_BYTES + brpp_pkg::DATA_BYTES_DEF + 4)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                command,
  input  logic [7:0]          record_key,
  input  logic [3:0]          bit_position,
  input  logic [15:0]         raw_value,
  input  logic [15:0]         field_mask,
  input  logic [31:0]         now_seconds,
  output brpp_pkg::brpp_job_t job,
  output logic [OFF_W-1:0]    patch_slot,
  output logic [OFF_W-1:0]    key_off,
  output logic [OFF_W-1:0]    val_off
);
  import brpp_pkg::*;

  localparam int CAPACITY = HEADER_BYTES + DATA_BYTES;
  localparam logic [OFF_W-1:0] CAP_OFF = OFF_W'(CAPACITY);
  localparam logic [OFF_W-1:0] HDR_OFF = OFF_W'(HEADER_BYTES);

  logic              record_open_r, record_open_nxt;
  logic [7:0]        open_key_r, open_key_nxt;
  logic [15:0]       presence_bits_r, presence_bits_nxt;
  logic [OFF_W-1:0]  bitmask_slot_r, bitmask_slot_nxt;
  logic [OFF_W-1:0]  fill_offset_r, fill_offset_nxt;
  logic [31:0]       previous_time_r, previous_time_nxt;

  logic [3:0]        tz;
  logic [15:0]       field;
  logic              new_rec;
  logic [OFF_W-1:0]  rec_off, fill_mid, sum_a, sum_b;
  logic [15:0]       bits_mid;
  logic [OFF_W+8:0]  len_ext;

  // Right-align the masked field by the mask's trailing zeros
  always_comb begin
    tz = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (field_mask[i]) tz = 4'(i);
    end
    field = (raw_value & field_mask) >> tz;
  end

  always_comb begin
    record_open_nxt   = record_open_r;
    open_key_nxt      = open_key_r;
    presence_bits_nxt = presence_bits_r;
    bitmask_slot_nxt  = bitmask_slot_r;
    fill_offset_nxt   = fill_offset_r;
    previous_time_nxt = previous_time_r;

    new_rec  = !record_open_r || (open_key_r != record_key);
    rec_off  = record_open_r ? fill_offset_r : HDR_OFF;
    sum_a    = rec_off + OFF_W'(3);
    fill_mid = new_rec ? ((sum_a > CAP_OFF) ? CAP_OFF : sum_a) : fill_offset_r;
    bits_mid = new_rec ? 16'd0 : presence_bits_r;
    sum_b    = fill_mid + OFF_W'(2);

    job            = '0;
    job.is_send    = (command == CMD_SEND);
    job.patch_bits = presence_bits_r;
    job.key        = record_key;
    job.value      = field;
    job.now_time   = now_seconds;
    job.old_time   = (previous_time_r != 32'd0) ? previous_time_r : now_seconds;
    patch_slot     = bitmask_slot_r;
    key_off        = rec_off;
    val_off        = fill_mid;

    if (command == CMD_ADD) begin
      job.patch_en      = new_rec && record_open_r;
      job.key_en        = new_rec;
      record_open_nxt   = 1'b1;
      open_key_nxt      = record_key;
      presence_bits_nxt = bits_mid | (16'd1 << bit_position);
      if (new_rec) bitmask_slot_nxt = rec_off + OFF_W'(1);
      fill_offset_nxt   = (sum_b > CAP_OFF) ? CAP_OFF : sum_b;
    end else begin
      job.patch_en      = record_open_r;
      record_open_nxt   = 1'b0;
      previous_time_nxt = now_seconds;
    end

    len_ext     = {{OUT_OFF_W{1'b0}}, fill_offset_nxt};
    job.pkt_len = len_ext[OUT_OFF_W-1:0];
    job.full    = (fill_offset_nxt >= CAP_OFF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_open_r   <= 1'b0;
      open_key_r      <= 8'd0;
      presence_bits_r <= 16'd0;
      bitmask_slot_r  <= '0;
      fill_offset_r   <= '0;
      previous_time_r <= 32'd0;
    end else if (accept) begin
      record_open_r   <= record_open_nxt;
      open_key_r      <= open_key_nxt;
      presence_bits_r <= presence_bits_nxt;
      bitmask_slot_r  <= bitmask_slot_nxt;
      fill_offset_r   <= fill_offset_nxt;
      previous_time_r <= previous_time_nxt;
    end
  end

endmodule

// ===== rtl/core/brpp_queue.sv =====
module brpp_queue #(
  parameter int W     = 8,
  parameter int DEPTH = brpp_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic [W-1:0]           wdata,
  input  logic                   pop,
  output logic [W-1:0]           rdata,
  output brpp_pkg::brpp_q_stat_t stat
);
  import brpp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [W-1:0]     slots_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign rdata      = slots_r[rptr_r];
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CNT_W'(1);
    if (pop && !push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wptr_r <= (wptr_r == LAST_PTR) ? '0 : wptr_r + PTR_W'(1);
      if (pop)  rptr_r <= (rptr_r == LAST_PTR) ? '0 : rptr_r + PTR_W'(1);
    end
  end

endmodule

// ===== rtl/core/brpp_back.sv =====
module brpp_back #(
  parameter int DATA_BYTES = brpp_pkg::DATA_BYTES_DEF,
  parameter int OFF_W      = $clog2(brpp_pkg::HEADER_BYTES + brpp_pkg::DATA_BYTES_DEF + 4)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                have_job,
  input  brpp_pkg::brpp_job_t job,
  input  logic [OFF_W-1:0]    patch_slot,
  input  logic [OFF_W-1:0]    key_off,
  input  logic [OFF_W-1:0]    val_off,
  input  logic [31:0]         device_uuid,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_write_enable,
  output logic [8:0]          out_write_offset,
  output logic [7:0]          out_write_data,
  output logic [8:0]          out_packet_length,
  output logic                out_full_flag,
  output logic                out_last_write
);
  import brpp_pkg::*;

  localparam int CAPACITY = HEADER_BYTES + DATA_BYTES;
  localparam logic [OFF_W-1:0] CAP_OFF = OFF_W'(CAPACITY);

  logic             started_r, started_nxt;
  logic [3:0]       step_r, step_nxt;
  logic             valid_r;
  logic             we_r, full_r, last_r;
  logic [8:0]       off_r, len_r;
  logic [7:0]       data_r;

  logic             load;
  logic [3:0]       first_body, s, last_step, h;
  logic             is_last;
  logic [OFF_W-1:0] off;
  logic [7:0]       byte_d;
  logic [95:0]      hdr, hdr_sh;
  logic [OFF_W+8:0] off_ext;

  assign load = have_job && (!valid_r || !out_stall);
  assign hdr  = {device_uuid, job.old_time, job.now_time};

  always_comb begin
    first_body = (job.is_send || job.key_en) ? STEP_BODY : STEP_VAL_LO;
    s          = started_r ? step_r : (job.patch_en ? STEP_PATCH_LO : first_body);
    last_step  = job.is_send ? STEP_HDR_LAST : STEP_VAL_HI;
    is_last    = (s == last_step);
    h          = s - STEP_BODY;
    hdr_sh     = hdr >> {h, 3'b000};

    case (s)
      STEP_PATCH_LO: begin
        off    = patch_slot;
        byte_d = job.patch_bits[7:0];
      end
      STEP_PATCH_HI: begin
        off    = patch_slot + OFF_W'(1);
        byte_d = job.patch_bits[15:8];
      end
      default: begin
        if (job.is_send) begin
          off    = OFF_W'(h);
          byte_d = hdr_sh[7:0];
        end else if (s == STEP_BODY) begin
          off    = key_off;
          byte_d = job.key;
        end else if (s == STEP_VAL_LO) begin
          off    = val_off;
          byte_d = job.value[7:0];
        end else begin
          off    = val_off + OFF_W'(1);
          byte_d = job.value[15:8];
        end
      end
    endcase

    off_ext = {{OUT_OFF_W{1'b0}}, off};

    started_nxt = started_r;
    step_nxt    = step_r;
    if (load) begin
      started_nxt = !is_last;
      step_nxt    = (s == STEP_PATCH_HI) ? first_body : s + 4'd1;
    end
  end

  assign pop = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      step_r    <= STEP_PATCH_LO;
      valid_r   <= 1'b0;
    end else begin
      started_r <= started_nxt;
      step_r    <= step_nxt;
      if (load)            valid_r <= 1'b1;
      else if (!out_stall) valid_r <= 1'b0;
    end
  end

  // Hold the beat while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      we_r   <= (off < CAP_OFF);
      off_r  <= off_ext[OUT_OFF_W-1:0];
      data_r <= byte_d;
      len_r  <= job.pkt_len;
      full_r <= job.full;
      last_r <= is_last;
    end
  end

  assign out_valid         = valid_r;
  assign out_write_enable  = we_r;
  assign out_write_offset  = off_r;
  assign out_write_data    = data_r;
  assign out_packet_length = len_r;
  assign out_full_flag     = full_r;
  assign out_last_write    = last_r;

endmodule

// ===== rtl/core/bitmask_record_packet_packer_top.sv =====
// Telemetry packet packer: each input item becomes a run of byte-write beats
// on the result channel, one beat per cycle unless the receiver stalls, with
// last_write marking the item's final beat. An add takes two beats, or three
// or five when it opens a record; a send takes twelve, or fourteen when a
// record is open. The beat sequencer in the back end sets the rate at one beat
// per cycle while out_stall is low. Items are accepted one per cycle while the
// two-entry job queue has room, so the front end classifies and updates packet
// state ahead of the byte writes.
// device_uuid is sampled by header beats and must only be written while idle.
module bitmask_record_packet_packer_top #(
  parameter int DATA_BYTES = brpp_pkg::DATA_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_record_key,
  input  logic [3:0]  in_bit_position,
  input  logic [15:0] in_raw_value,
  input  logic [15:0] in_field_mask,
  input  logic [31:0] in_now_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_write_enable,
  output logic [8:0]  out_write_offset,
  output logic [7:0]  out_write_data,
  output logic [8:0]  out_packet_length,
  output logic        out_full_flag,
  output logic        out_last_write
);
  import brpp_pkg::*;

  localparam int OFF_W = $clog2(HEADER_BYTES + DATA_BYTES + 4);
  localparam int JOB_W = $bits(brpp_job_t);
  localparam int Q_W   = JOB_W + 3 * OFF_W;

  logic [31:0]      device_uuid_r;
  logic             accept;
  brpp_job_t        f_job, b_job;
  logic [OFF_W-1:0] f_slot, f_key_off, f_val_off;
  logic [OFF_W-1:0] b_slot, b_key_off, b_val_off;
  logic [Q_W-1:0]   q_wdata, q_rdata;
  brpp_q_stat_t     q_stat;
  logic             back_pop;

  always_ff @(posedge clk) begin
    if (!rst_n)            device_uuid_r <= 32'd0;
    else if (cfg_write_en) device_uuid_r <= cfg_write_data;
  end

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  brpp_front #(.DATA_BYTES(DATA_BYTES), .OFF_W(OFF_W)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .command      (in_command),
    .record_key   (in_record_key),
    .bit_position (in_bit_position),
    .raw_value    (in_raw_value),
    .field_mask   (in_field_mask),
    .now_seconds  (in_now_seconds),
    .job          (f_job),
    .patch_slot   (f_slot),
    .key_off      (f_key_off),
    .val_off      (f_val_off)
  );

  assign q_wdata = {f_job, f_slot, f_key_off, f_val_off};
  assign {b_job, b_slot, b_key_off, b_val_off} = q_rdata;

  brpp_queue #(.W(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .wdata (q_wdata),
    .pop   (back_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  brpp_back #(.DATA_BYTES(DATA_BYTES), .OFF_W(OFF_W)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .have_job          (!q_stat.empty),
    .job               (b_job),
    .patch_slot        (b_slot),
    .key_off           (b_key_off),
    .val_off           (b_val_off),
    .device_uuid       (device_uuid_r),
    .pop               (back_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_write_enable  (out_write_enable),
    .out_write_offset  (out_write_offset),
    .out_write_data    (out_write_data),
    .out_packet_length (out_packet_length),
    .out_full_flag     (out_full_flag),
    .out_last_write    (out_last_write)
  );

  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("job queue reports full and empty together");

  a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    back_pop |-> !q_stat.empty)
    else $error("back end popped an empty job queue");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    back_pop |=> (out_valid && out_last_write))
    else $error("job retired without a last beat");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import brpp_pkg::*;

  localparam int CAPACITY = HEADER_BYTES + DATA_BYTES_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_SLACK = 16;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic       byte_en;
    logic [8:0] offset;
    logic [7:0] data;
    logic [8:0] length;
    logic       full;
    logic       last_write;
  } byte_write_t;

  class packet_write_predictor;
    logic        rec_open;
    logic [7:0]  cur_key;
    logic [15:0] bits;
    int          mask_slot;
    int          fill;
    logic [31:0] last_time;
    logic [31:0] uuid;
    int          errors;
    byte_write_t item_writes[$];
    byte_write_t pending_writes[$];

    function new();
      rec_open = 1'b0;
      cur_key = '0;
      bits = '0;
      mask_slot = 0;
      fill = 0;
      last_time = '0;
      uuid = '0;
      errors = 0;
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction

    function int clamp_fill(int x);
      return (x > CAPACITY) ? CAPACITY : x;
    endfunction

    // Mask, then shift the field down to bit zero
    function logic [15:0] align_field(logic [15:0] raw, logic [15:0] mask);
      logic [15:0] v;
      logic [15:0] m;
      v = raw & mask;
      m = mask;
      if (m == 16'h0000) return 16'h0000;
      while (!m[0]) begin
        m = m >> 1;
        v = v >> 1;
      end
      return v;
    endfunction

    function void put_byte(int off, logic [7:0] data);
      byte_write_t w;
      w = '0;
      w.byte_en = (off < CAPACITY);
      w.offset = off[8:0];
      w.data = data;
      item_writes.push_back(w);
    endfunction

    function void put_word(int off, logic [15:0] v);
      put_byte(off, v[7:0]);
      put_byte(off + 1, v[15:8]);
    endfunction

    function void put_long(int off, logic [31:0] v);
      put_word(off, v[15:0]);
      put_word(off + 2, v[31:16]);
    endfunction

    function void note_item(logic cmd, logic [7:0] key, logic [3:0] bitpos,
                            logic [15:0] raw, logic [15:0] mask, logic [31:0] now);
      int key_off;
      logic [31:0] old_time;
      item_writes.delete();
      if (cmd == CMD_ADD) begin
        if (!rec_open || cur_key != key) begin
          // back-patch the record being closed, then open the new one
          if (rec_open) begin
            put_word(mask_slot, bits);
            key_off = fill;
          end else begin
            key_off = HEADER_BYTES;
          end
          put_byte(key_off, key);
          mask_slot = key_off + 1;
          fill = clamp_fill(key_off + 3);
          bits = '0;
          cur_key = key;
          rec_open = 1'b1;
        end
        bits = bits | (16'h0001 << bitpos);
        put_word(fill, align_field(raw, mask));
        fill = clamp_fill(fill + 2);
      end else begin
        old_time = (last_time != 32'h0) ? last_time : now;
        if (rec_open) put_word(mask_slot, bits);
        put_long(0, now);
        put_long(4, old_time);
        put_long(8, uuid);
        last_time = now;
        rec_open = 1'b0;
      end
      foreach (item_writes[k]) begin
        item_writes[k].length = fill[8:0];
        item_writes[k].full = (fill >= CAPACITY);
        item_writes[k].last_write = (k == item_writes.size() - 1);
        pending_writes.push_back(item_writes[k]);
      end
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_write(byte_write_t got);
      byte_write_t exp_w;
      if (pending_writes.size() == 0) begin
        $error("unexpected write beat: offset %0d data %0d", got.offset, got.data);
        errors++;
        return;
      end
      exp_w = pending_writes.pop_front();
      compare_field("write_enable", exp_w.byte_en, got.byte_en);
      compare_field("write_offset", exp_w.offset, got.offset);
      compare_field("write_data", exp_w.data, got.data);
      compare_field("packet_length", exp_w.length, got.length);
      compare_field("full_flag", exp_w.full, got.full);
      compare_field("last_write", exp_w.last_write, got.last_write);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_write_en = 1'b0;
  logic [31:0] cfg_write_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = CMD_ADD;
  logic [7:0]  in_record_key = '0;
  logic [3:0]  in_bit_position = '0;
  logic [15:0] in_raw_value = '0;
  logic [15:0] in_field_mask = '0;
  logic [31:0] in_now_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_write_enable;
  logic [8:0]  out_write_offset;
  logic [7:0]  out_write_data;
  logic [8:0]  out_packet_length;
  logic        out_full_flag;
  logic        out_last_write;

  packet_write_predictor packer_model = new();

  int idle_pct = 0;
  int stall_pct = 0;
  int items_offered = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  logic [7:0] walk_key = '0;

  bitmask_record_packet_packer_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_record_key(in_record_key),
    .in_bit_position(in_bit_position),
    .in_raw_value(in_raw_value),
    .in_field_mask(in_field_mask),
    .in_now_seconds(in_now_seconds),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_write_enable(out_write_enable),
    .out_write_offset(out_write_offset),
    .out_write_data(out_write_data),
    .out_packet_length(out_packet_length),
    .out_full_flag(out_full_flag),
    .out_last_write(out_last_write)
  );

  always #6 clk = ~clk;

  // Receiver: random stalls, or a long hold when requested
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    byte_write_t got;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      got.byte_en = out_write_enable;
      got.offset = out_write_offset;
      got.data = out_write_data;
      got.length = out_packet_length;
      got.full = out_full_flag;
      got.last_write = out_last_write;
      packer_model.check_write(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) || cfg_write_en)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic offer_item(logic cmd, logic [7:0] key, logic [3:0] bitpos,
                            logic [15:0] raw, logic [15:0] mask, logic [31:0] now);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_record_key <= key;
    in_bit_position <= bitpos;
    in_raw_value <= raw;
    in_field_mask <= mask;
    in_now_seconds <= now;
    items_offered++;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    packer_model.note_item(cmd, key, bitpos, raw, mask, now);
  endtask

  task automatic add_value(logic [7:0] key, logic [3:0] bitpos, logic [15:0] raw,
                           logic [15:0] mask);
    offer_item(CMD_ADD, key, bitpos, raw, mask, $urandom);
  endtask

  task automatic close_packet(logic [31:0] now);
    offer_item(CMD_SEND, 8'($urandom), 4'($urandom), 16'($urandom), 16'($urandom), now);
  endtask

  function automatic logic [15:0] pick_mask();
    int sel;
    int lo;
    int hi;
    sel = $urandom_range(9);
    if (sel == 0) return 16'h0000;
    if (sel == 1) return 16'hFFFF;
    if (sel < 6) return 16'($urandom);
    // contiguous field
    lo = $urandom_range(15);
    hi = $urandom_range(15, lo);
    return 16'(((32'h1 << (hi + 1)) - 1) & ~((32'h1 << lo) - 1));
  endfunction

  function automatic logic [31:0] pick_time();
    return ($urandom_range(9) == 0) ? 32'h0 : 32'($urandom);
  endfunction

  task automatic run_packet(int n_adds, int change_pct);
    for (int i = 0; i < n_adds; i++) begin
      if ($urandom_range(99) < change_pct) walk_key = walk_key + 8'($urandom_range(1, 255));
      add_value(walk_key, 4'($urandom), 16'($urandom), pick_mask());
    end
    close_packet(pick_time());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (packer_model.pending() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_uuid(logic [31:0] v);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    packer_model.uuid = v;
  endtask

  task automatic run_phase(int budget, bit overflow, bit pressure);
    int stop;
    stop = items_offered + budget;
    // one packet long enough to run past the end of the buffer
    if (overflow) run_packet(60, 100);
    if (pressure) begin
      hold_req = 1'b1;
      run_packet(12, 50);
      wait_drained();
    end
    while (items_offered < stop) begin
      if ($urandom_range(9) == 0) close_packet(pick_time());
      else run_packet($urandom_range(1, 8), 30);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_uuid(32'($urandom));

    // send on an empty packet, with no stored time
    close_packet(32'h1234_5678);
    close_packet(32'h0000_0000);
    close_packet(32'hFFFF_FFFF);
    // first record after a send, zero mask, widest and narrowest fields
    add_value(8'h00, 4'd0, 16'hFFFF, 16'h0000);
    add_value(8'h00, 4'd15, 16'hFFFF, 16'hFFFF);
    add_value(8'h00, 4'd7, 16'hA5C3, 16'h8000);
    add_value(8'hFF, 4'd3, 16'h1234, 16'h0FF0);
    add_value(8'hFF, 4'd15, 16'h0000, 16'h0001);
    add_value(8'h80, 4'd1, 16'h5555, 16'hAAAA);
    add_value(8'h01, 4'd8, 16'hFFFF, 16'h7FFE);
    close_packet(32'h0000_0000);
    close_packet(32'h0000_0001);
    add_value(8'h7F, 4'd12, 16'h8001, 16'h8001);
    close_packet(32'hFFFF_FFFF);
    wait_drained();

    write_uuid(32'($urandom));
    idle_pct = 0;
    stall_pct = 0;
    run_phase(40, 1'b0, 1'b1);
    wait_drained();

    write_uuid(32'hFFFF_FFFF);
    idle_pct = 84;
    stall_pct = 0;
    run_phase(35, 1'b0, 1'b0);
    wait_drained();

    write_uuid(32'h0000_0000);
    idle_pct = 0;
    stall_pct = 84;
    run_phase(45, 1'b1, 1'b0);
    wait_drained();

    write_uuid(32'($urandom));
    idle_pct = 10;
    stall_pct = 10;
    run_phase(20, 1'b0, 1'b0);
    wait_drained();

    if (packer_model.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
